>>> rtl/mbrs_pkg.sv
// shared types and constants for the modbus rtu register slave
// no dependencies
package mbrs_pkg;

  localparam logic [7:0]  FnRead    = 8'h03;
  localparam logic [7:0]  FnWrite   = 8'h06;
  localparam logic [7:0]  MinFrame  = 8'd8;
  localparam logic [16:0] ResetFill = 17'd11;
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [15:0] CrcInit   = 16'hFFFF;

  typedef struct packed {
    logic       init;
    logic       feed;
    logic [7:0] data;
  } crc_cmd_t;

endpackage

>>> rtl/mbrs_crc.sv
// bit-serial crc-16/modbus unit, one bit per cycle
// depends on mbrs_pkg
module mbrs_crc import mbrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  crc_cmd_t    cmd,
  output logic [15:0] crc,
  output logic        busy
);

  logic [7:0] sh;
  logic [3:0] cnt;
  logic       fb;

  assign busy = (cnt != 4'd0);
  assign fb   = crc[0] ^ sh[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CrcInit;
      cnt <= 4'd0;
    end else if (cmd.init) begin
      crc <= CrcInit;
      cnt <= 4'd0;
    end else if (cmd.feed) begin
      sh  <= cmd.data;
      cnt <= 4'd8;
    end else if (busy) begin
      crc <= fb ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
      sh  <= sh >> 1;
      cnt <= cnt - 4'd1;
    end
  end

endmodule

>>> rtl/mbrs_regbank.sv
// holding register memory, one write and one registered read port
// runs a clearing pass after reset; depends on mbrs_pkg
module mbrs_regbank import mbrs_pkg::*; #(
  parameter int REG_COUNT = 256,
  parameter int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data,
  output logic          ready
);

  localparam logic [AW-1:0] LastAddr = AW'(REG_COUNT - 1);

  logic [15:0]   mem [REG_COUNT];
  logic [AW-1:0] clr_addr;
  logic          clearing;
  logic          we;
  logic [AW-1:0] wa;
  logic [15:0]   wd;

  assign ready = !clearing;

  always_comb begin
    if (clearing) begin
      we = 1'b1;
      wa = clr_addr;
      wd = (17'(clr_addr) < ResetFill) ? 16'(clr_addr) : 16'd0;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LastAddr) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/modbus_rtu_register_slave_top.sv
// modbus rtu slave top: frame intake, request check and reply sequencer
// depends on mbrs_pkg, mbrs_crc, mbrs_regbank
//
// usage:
//   rx channel (rx_valid/rx_ready) takes one frame byte per beat, rx_last on
//   the final byte. tx channel (tx_valid/tx_ready) gives reply bytes in send
//   order, tx_last on the final crc byte. cfg channel (cfg_valid/cfg_ready)
//   writes the station address and is always ready.
//   a byte is taken only while the bit-serial crc unit is idle; that unit
//   shifts in each byte that enters the running crc. after the last byte
//   the frame is checked once the crc settles; each reply byte before the
//   crc then passes memory read, byte select, crc update and output beat,
//   plus the receiver's stall, and the two crc bytes follow, one beat each.
//   rx is not taken while a reply is being sent.
//   reset: synchronous; afterwards the register memory is swept one entry
//   per cycle with rx held off. cfg is taken throughout.
//   a stalled receiver simply holds tx_byte/tx_last and the sequencer.
module modbus_rtu_register_slave_top import mbrs_pkg::*; #(
  parameter int REG_COUNT = 256,
  parameter int MAX_READ  = 29
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  input  logic       rx_last,
  output logic       tx_valid,
  input  logic       tx_ready,
  output logic [7:0] tx_byte,
  output logic       tx_last
);

  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [16:0] RegLimit = 17'(REG_COUNT);
  localparam logic [15:0] ReadMax  = 16'(MAX_READ);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_BYTE  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_CRC0  = 3'd6;
  localparam logic [2:0] S_CRC1  = 3'd7;

  logic [2:0]    state;
  logic [7:0]    slave_address;
  logic [7:0]    hdr [6];
  logic [7:0]    tail0, tail1;
  logic [7:0]    byte_count;
  logic          rep_read;
  logic [15:0]   rep_a, rep_v;
  logic [5:0]    rep_len;
  logic [5:0]    k;
  logic [AW-1:0] rd_addr;

  crc_cmd_t      crc_cmd;
  logic [15:0]   crc;
  logic          crc_busy;
  logic          bank_ready;
  logic          wr_en, rd_en;
  logic [15:0]   rd_data;

  logic          rx_beat, tx_beat;
  logic [15:0]   a_in, v_in;
  logic          frame_ok, read_ok, write_ok;
  logic [7:0]    byte_next;

  assign cfg_ready = 1'b1;
  assign rx_ready  = (state == S_IDLE) && !crc_busy;
  assign rx_beat   = rx_valid && rx_ready;
  assign tx_valid  = ((state == S_OUT) && !crc_busy) || (state == S_CRC0) || (state == S_CRC1);
  assign tx_beat   = tx_valid && tx_ready;

  assign a_in     = {hdr[2], hdr[3]};
  assign v_in     = {hdr[4], hdr[5]};
  assign frame_ok = (byte_count >= MinFrame) && ({tail1, tail0} == crc)
                    && (hdr[0] == slave_address);
  assign read_ok  = frame_ok && (hdr[1] == FnRead) && (v_in != 16'd0)
                    && (v_in <= ReadMax) && ((17'(a_in) + 17'(v_in)) <= RegLimit);
  assign write_ok = frame_ok && (hdr[1] == FnWrite) && (17'(a_in) < RegLimit);

  assign wr_en = (state == S_CHECK) && !crc_busy && write_ok;
  assign rd_en = (state == S_FETCH) && rep_read && (k >= 6'd3) && k[0];

  always_comb begin
    crc_cmd.init = ((state == S_CHECK) && !crc_busy) || ((state == S_CRC1) && tx_beat);
    crc_cmd.feed = 1'b0;
    crc_cmd.data = tail0;
    if (rx_beat && (byte_count >= 8'd2)) begin
      crc_cmd.feed = 1'b1;
    end
    if (state == S_BYTE) begin
      crc_cmd.feed = 1'b1;
      crc_cmd.data = byte_next;
    end
  end

  always_comb begin
    unique case (k)
      6'd0:    byte_next = slave_address;
      6'd1:    byte_next = rep_read ? FnRead : FnWrite;
      6'd2:    byte_next = rep_read ? {rep_v[6:0], 1'b0} : rep_a[15:8];
      6'd3:    byte_next = rep_read ? rd_data[15:8] : rep_a[7:0];
      6'd4:    byte_next = rep_read ? rd_data[7:0] : rep_v[15:8];
      6'd5:    byte_next = rep_read ? rd_data[15:8] : rep_v[7:0];
      default: byte_next = k[0] ? rd_data[15:8] : rd_data[7:0];
    endcase
  end

  mbrs_crc u_crc (
    .clk  (clk),
    .rst  (rst),
    .cmd  (crc_cmd),
    .crc  (crc),
    .busy (crc_busy)
  );

  mbrs_regbank #(
    .REG_COUNT (REG_COUNT),
    .AW        (AW)
  ) u_bank (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (a_in[AW-1:0]),
    .wr_data (v_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .ready   (bank_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      slave_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      byte_count <= 8'd0;
      tail0      <= 8'd0;
      tail1      <= 8'd0;
      for (int i = 0; i < 6; i++) begin
        hdr[i] <= 8'd0;
      end
      k          <= 6'd0;
      tx_last    <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (bank_ready) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (rx_beat) begin
            if (byte_count < 8'd6) begin
              hdr[byte_count[2:0]] <= rx_byte;
            end
            tail0 <= tail1;
            tail1 <= rx_byte;
            if (byte_count != 8'hFF) begin
              byte_count <= byte_count + 8'd1;
            end
            if (rx_last) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (!crc_busy) begin
            rep_read   <= read_ok;
            rep_a      <= a_in;
            rep_v      <= v_in;
            rep_len    <= read_ok ? (6'd3 + {v_in[4:0], 1'b0}) : 6'd6;
            rd_addr    <= a_in[AW-1:0];
            k          <= 6'd0;
            byte_count <= 8'd0;
            tail0      <= 8'd0;
            tail1      <= 8'd0;
            for (int i = 0; i < 6; i++) begin
              hdr[i] <= 8'd0;
            end
            state <= (read_ok || write_ok) ? S_FETCH : S_IDLE;
          end
        end
        S_FETCH: begin
          if (rd_en) begin
            rd_addr <= rd_addr + 1'b1;
          end
          state <= S_BYTE;
        end
        S_BYTE: begin
          tx_byte <= byte_next;
          tx_last <= 1'b0;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (tx_beat) begin
            if (k == rep_len - 6'd1) begin
              tx_byte <= crc[7:0];
              state   <= S_CRC0;
            end else begin
              k     <= k + 6'd1;
              state <= S_FETCH;
            end
          end
        end
        S_CRC0: begin
          if (tx_beat) begin
            tx_byte <= crc[15:8];
            tx_last <= 1'b1;
            state   <= S_CRC1;
          end
        end
        S_CRC1: begin
          if (tx_beat) begin
            tx_last <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rx_crc_free: assert property (@(posedge clk) disable iff (rst)
    rx_beat |-> !crc_busy)
    else $error("rx beat taken while crc unit busy");

  a_clear_blocks_rx: assert property (@(posedge clk) disable iff (rst)
    !bank_ready |-> !rx_ready)
    else $error("rx ready during memory clearing pass");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    tx_beat && tx_last |=> state == S_IDLE)
    else $error("sequencer not idle after final reply beat");

  a_write_checked: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> frame_ok && hdr[1] == FnWrite)
    else $error("register write without a valid write request");

endmodule
